### rtl/srx_pkg.sv
// Shared types, constants and helper functions of the shift register output expander.
package srx_pkg;

   localparam int MAX_REGS = 4;
   localparam int IMAGE_W  = 32;
   localparam int REGS_W   = 3;
   localparam int PIN_W    = 5;
   localparam int COUNT_W  = 6;

   localparam logic [REGS_W-1:0] REGS_RESET = REGS_W'(MAX_REGS);

   typedef enum logic [3:0] {
      ACT_WR_PIN   = 4'd0,
      ACT_WR_STAGE = 4'd1,
      ACT_READ     = 4'd2,
      ACT_CLR_ALL  = 4'd3,
      ACT_SET_ALL  = 4'd4,
      ACT_MASK_CLR = 4'd5,
      ACT_MASK_SET = 4'd6,
      ACT_STAMP    = 4'd7,
      ACT_COPY     = 4'd8,
      ACT_COMMIT   = 4'd9,
      ACT_DISCARD  = 4'd10
   } action_type;

   typedef struct packed {
      logic               push;
      logic [REGS_W-1:0]  regs;
      logic [IMAGE_W-1:0] image;
      logic               read_bit;
      logic               ok;
   } job_type;

   function automatic logic [REGS_W-1:0] clamp_regs(input logic [REGS_W-1:0] raw);
      logic [REGS_W-1:0] result;
      if (raw == '0) begin
         result = REGS_W'(1);
      end else if (raw > REGS_W'(MAX_REGS)) begin
         result = REGS_W'(MAX_REGS);
      end else begin
         result = raw;
      end
      return result;
   endfunction

   function automatic logic [COUNT_W-1:0] pin_count(input logic [REGS_W-1:0] regs);
      return {regs, 3'b000};
   endfunction

   function automatic logic [IMAGE_W-1:0] active_mask(input logic [REGS_W-1:0] regs);
      return {IMAGE_W{1'b1}} >> (COUNT_W'(IMAGE_W) - pin_count(regs));
   endfunction

endpackage

### rtl/srx_image.sv
// Main and staging output images, updated once for each accepted word.
module srx_image (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic [3:0]                    action,
   input  logic [srx_pkg::PIN_W-1:0]     pin,
   input  logic                          value,
   input  logic [srx_pkg::IMAGE_W-1:0]   bits,
   input  logic                          flag,
   input  logic [srx_pkg::REGS_W-1:0]    active_regs,
   output srx_pkg::job_type              job
);
   import srx_pkg::*;

   logic [IMAGE_W-1:0] main_ff, main_in;
   logic [IMAGE_W-1:0] stage_ff, stage_in;
   logic               valid_ff, valid_in;

   logic [REGS_W-1:0]  regs;
   logic [IMAGE_W-1:0] mask;
   logic [IMAGE_W-1:0] pbit;
   logic [IMAGE_W-1:0] taken;
   logic [IMAGE_W-1:0] base;
   logic               pin_ok;

   always_comb begin
      regs   = clamp_regs(active_regs);
      mask   = active_mask(regs);
      pbit   = IMAGE_W'(1) << pin;
      pin_ok = {1'b0, pin} < pin_count(regs);
      taken  = valid_ff ? ((main_ff & ~mask) | (stage_ff & mask)) : main_ff;
      base   = valid_ff ? stage_ff : main_ff;

      main_in      = main_ff;
      stage_in     = stage_ff;
      valid_in     = valid_ff;
      job.push     = 1'b0;
      job.regs     = regs;
      job.read_bit = 1'b0;
      job.ok       = 1'b1;

      unique case (action)
         ACT_WR_PIN: begin
            if (pin_ok) begin
               main_in  = value ? (taken | pbit) : (taken & ~pbit);
               valid_in = 1'b0;
               job.push = 1'b1;
            end else begin
               job.ok = 1'b0;
            end
         end
         ACT_WR_STAGE: begin
            if (pin_ok) begin
               stage_in = value ? (base | pbit) : (base & ~pbit);
               valid_in = 1'b1;
            end else begin
               job.ok = 1'b0;
            end
         end
         ACT_READ: begin
            if (pin_ok) begin
               main_in      = taken;
               valid_in     = 1'b0;
               job.push     = valid_ff;
               job.read_bit = taken[pin];
            end else begin
               job.ok = 1'b0;
            end
         end
         ACT_CLR_ALL: begin
            main_in  = main_ff & ~mask;
            valid_in = 1'b0;
            job.push = 1'b1;
         end
         ACT_SET_ALL: begin
            main_in  = main_ff | mask;
            valid_in = 1'b0;
            job.push = 1'b1;
         end
         ACT_MASK_CLR: begin
            main_in  = taken & ~(bits & mask);
            valid_in = 1'b0;
            job.push = 1'b1;
         end
         ACT_MASK_SET: begin
            main_in  = taken | (bits & mask);
            valid_in = 1'b0;
            job.push = 1'b1;
         end
         ACT_STAMP: begin
            main_in  = (main_ff & ~mask) | (bits & mask);
            valid_in = 1'b0;
            job.push = 1'b1;
         end
         ACT_COPY: begin
            if (!valid_ff || flag) begin
               stage_in = main_ff;
               valid_in = 1'b1;
            end else begin
               job.ok = 1'b0;
            end
         end
         ACT_COMMIT: begin
            if (valid_ff) begin
               main_in  = taken;
               valid_in = 1'b0;
               job.push = flag;
            end
         end
         ACT_DISCARD: begin
            valid_in = 1'b0;
         end
         default: begin
            job.ok = 1'b0;
         end
      endcase

      job.image = main_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (req_accept) begin
         main_ff  <= main_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### rtl/srx_serial.sv
// Frame shifter: sends the image one bit per word, highest pin first, when the job pushes it, then the reply.
module srx_serial (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  srx_pkg::job_type job,
   output logic             busy,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import srx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_REPLY = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IMAGE_W-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rbit_ff, rbit_in;
   logic               ok_ff, ok_in;

   logic out_valid_ff, out_valid_in;
   logic out_kind_ff, out_kind_in;
   logic out_sbit_ff, out_sbit_in;
   logic out_fend_ff, out_fend_in;
   logic out_rbit_ff, out_rbit_in;
   logic out_ok_ff, out_ok_in;
   logic out_last_ff, out_last_in;

   logic can_load;

   always_comb begin
      can_load     = !out_valid_ff || rsp_tready;
      state_in     = state_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      rbit_in      = rbit_ff;
      ok_in        = ok_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_sbit_in  = out_sbit_ff;
      out_fend_in  = out_fend_ff;
      out_rbit_in  = out_rbit_ff;
      out_ok_in    = out_ok_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rbit_in  = job.read_bit;
               ok_in    = job.ok;
               count_in = pin_count(job.regs);
               shift_in = job.image << (COUNT_W'(IMAGE_W) - pin_count(job.regs));
               state_in = job.push ? ST_SHIFT : ST_REPLY;
            end
         end
         ST_SHIFT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = 1'b0;
               out_sbit_in  = shift_ff[IMAGE_W-1];
               out_fend_in  = count_ff == COUNT_W'(1);
               out_rbit_in  = 1'b0;
               out_ok_in    = 1'b0;
               out_last_in  = 1'b0;
               shift_in     = shift_ff << 1;
               count_in     = count_ff - COUNT_W'(1);
               if (count_ff == COUNT_W'(1)) begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_REPLY: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = 1'b1;
               out_sbit_in  = 1'b0;
               out_fend_in  = 1'b0;
               out_rbit_in  = rbit_ff;
               out_ok_in    = ok_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      count_ff    <= count_in;
      rbit_ff     <= rbit_in;
      ok_ff       <= ok_in;
      out_kind_ff <= out_kind_in;
      out_sbit_ff <= out_sbit_in;
      out_fend_ff <= out_fend_in;
      out_rbit_ff <= out_rbit_in;
      out_ok_ff   <= out_ok_in;
      out_last_ff <= out_last_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_ok_ff, out_rbit_ff, out_fend_ff, out_sbit_ff};

endmodule

### rtl/shift_register_output_expander.sv
// Top level of the serial shift register output expander.
//
// Each request word names one action on the output image of a chain of 8-bit
// latched shift registers. A word is taken when req_tvalid and req_tready are
// both high; the block then works on that word alone. An action that changes
// the outputs (a commit only with flag set) sends a frame of response words,
// 8 per active register with active_regs clamped to 1..4, one serial bit
// each, highest pin first, with frame_end set on the final bit. Every request
// ends with one reply word (rsp_tuser high, rsp_tlast high). Acceptance moves
// the shifter out of idle, and each response word is then loaded into the
// output register; the frame shifter moves one bit per cycle while the
// output register can take a word. The next request is taken once the
// reply has been loaded into the output register.
// When the receiver stalls, the output register holds its word and the
// shifter waits. The csr channel writes active_regs at any time it is valid.
// Reset clears the main image, drops the staging image and sets active_regs
// to its maximum of four registers.
module shift_register_output_expander (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // action[3:0], pin[8:4], value[9], bits[41:10], flag[42], zero[47:43]
   input  logic [47:0]                 req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // serial_bit[0], frame_end[1], read_bit[2], ok[3], zero[7:4]
   output logic [7:0]                  rsp_tdata,
   // kind[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [srx_pkg::REGS_W-1:0]  csr_data
);
   import srx_pkg::*;

   logic [REGS_W-1:0] regs_ff, regs_in;
   logic              busy;
   logic              req_accept;
   job_type           job;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy;
   assign req_accept = req_tvalid && req_tready;
   assign regs_in    = (csr_valid && csr_ready) ? csr_data : regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REGS_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   srx_image u_image (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .action      (req_tdata[3:0]),
      .pin         (req_tdata[8:4]),
      .value       (req_tdata[9]),
      .bits        (req_tdata[41:10]),
      .flag        (req_tdata[42]),
      .active_regs (regs_ff),
      .job         (job)
   );

   srx_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .job        (job),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/srx_checker.sv
// Port-level checks of the shift register output expander, bound to the top level.
module srx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("A stalled response word was withdrawn.");

   a_frame_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tlast && !rsp_tdata[2] && !rsp_tdata[3])
      else $error("A frame bit carries reply fields.");

   a_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && !rsp_tdata[0] && !rsp_tdata[1])
      else $error("A reply is not marked last or carries frame fields.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("A request word was taken while the previous one was in progress.");

endmodule

bind shift_register_output_expander srx_checker u_srx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
